FILE: src/svrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svrc_pkg
// Shared constants and types for the saturated vector rate controller.
// ----------------------------------------------------------------------------
package svrc_pkg;

  localparam int GAIN_W     = 24;  // falloff gain, unsigned Q0.24
  localparam int GAIN_FRAC  = 24;  // fraction bits of length * gain
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_TARGET_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TORQUE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FALLOFF    = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } svrc_qstat_t;

endpackage
`default_nettype wire

FILE: src/saturated_vector_rate_controller_unit.sv
`default_nettype none
// Requests pass the input register, the queue and the back pipeline to the result;
//   a stall on the result side holds the back pipeline.
// Throughput: one request per cycle unless the queue is full; root and divide stages pipelined.
// Reset (rst_n low, synchronous): pipeline and queue emptied, all registers read 0.
// ----------------------------------------------------------------------------
// saturated_vector_rate_controller_unit
// Proportional rate controller: torque = min(|e|*max*gain, max) along e/|e|.
// ----------------------------------------------------------------------------
module saturated_vector_rate_controller_unit import svrc_pkg::*; #(
  parameter int VALUE_WIDTH = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel: tdata = current_x, current_y, current_z (lowest first)
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [((3*VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  // result channel: tdata = torque_x, torque_y, torque_z (lowest first)
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [((3*VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  // configuration
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]       cfg_prdata,
  output logic                        cfg_pready
);

  localparam int W  = VALUE_WIDTH;
  localparam int TW = ((3*W+7)/8)*8;
  localparam int PW = 3*W+3;

  // ---------------- configuration registers
  logic [W-1:0]        tgt_x_r, tgt_y_r, tgt_z_r;
  logic [W-2:0]        max_torque_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [REG_IDX_W-1:0] idx;
  logic                wr;

  assign cfg_pready = 1'b1;
  assign idx = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_x_r      <= '0;
      tgt_y_r      <= '0;
      tgt_z_r      <= '0;
      max_torque_r <= '0;
      gain_r       <= '0;
    end else if (wr) begin
      case (idx)
        REG_TARGET_X:   tgt_x_r      <= cfg_pwdata[W-1:0];
        REG_TARGET_Y:   tgt_y_r      <= cfg_pwdata[W-1:0];
        REG_TARGET_Z:   tgt_z_r      <= cfg_pwdata[W-1:0];
        REG_MAX_TORQUE: max_torque_r <= cfg_pwdata[W-2:0];
        REG_FALLOFF:    gain_r       <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TARGET_X:   cfg_prdata = CFG_DATA_W'(tgt_x_r);
      REG_TARGET_Y:   cfg_prdata = CFG_DATA_W'(tgt_y_r);
      REG_TARGET_Z:   cfg_prdata = CFG_DATA_W'(tgt_z_r);
      REG_MAX_TORQUE: cfg_prdata = CFG_DATA_W'(max_torque_r);
      REG_FALLOFF:    cfg_prdata = CFG_DATA_W'(gain_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- front: error sign and magnitude
  logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_en;
  logic [PW-1:0] q_push_data, q_pop_data;
  svrc_qstat_t   q_stat;

  svrc_front #(.W(W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cur_x      (in_tdata[W-1:0]),
    .cur_y      (in_tdata[2*W-1:W]),
    .cur_z      (in_tdata[3*W-1:2*W]),
    .tgt_x      (tgt_x_r),
    .tgt_y      (tgt_y_r),
    .tgt_z      (tgt_z_r),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  // ---------------- queue: lets the front keep taking requests while back stalls
  svrc_fifo #(.DW(PW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_en     (q_pop_en),
    .pop_data   (q_pop_data),
    .stat       (q_stat)
  );

  // ---------------- back: length, magnitude, per-axis scaling
  logic [W-1:0] tq_x, tq_y, tq_z;

  svrc_back #(.W(W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_pop_valid),
    .pop_en     (q_pop_en),
    .pop_data   (q_pop_data),
    .max_torque (max_torque_r),
    .gain       (gain_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .tq_x       (tq_x),
    .tq_y       (tq_y),
    .tq_z       (tq_z)
  );

  assign out_tdata = TW'({tq_z, tq_y, tq_x});

`ifndef SYNTH
  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // queue pops at most one per cycle, so full cannot turn empty in the next cycle
  a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |=> !q_stat.empty)
    else $error("queue drained too fast");

  // zero torque limit gives zero torque on all axes
  a_zero_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (max_torque_r == '0) |->
      (tq_x == '0) && (tq_y == '0) && (tq_z == '0))
    else $error("torque with zero limit");
`endif

endmodule
`default_nettype wire

FILE: src/svrc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svrc_front
// Input register; forms per-axis error sign and magnitude for the queue.
// ----------------------------------------------------------------------------
module svrc_front import svrc_pkg::*; #(
  parameter int W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [W-1:0]     cur_x,
  input  wire logic [W-1:0]     cur_y,
  input  wire logic [W-1:0]     cur_z,
  input  wire logic [W-1:0]     tgt_x,
  input  wire logic [W-1:0]     tgt_y,
  input  wire logic [W-1:0]     tgt_z,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output logic [3*W+2:0]        push_data   // mag x,y,z then sign x,y,z
);

  logic         v_r;
  logic [W-1:0] cx_r, cy_r, cz_r;
  logic [W:0]   ex, ey, ez, ax, ay, az;

  assign in_ready   = !v_r || push_ready;
  assign push_valid = v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cx_r <= cur_x;
      cy_r <= cur_y;
      cz_r <= cur_z;
    end
  end

  // exact W+1 bit error; magnitude fits in W bits
  assign ex = {tgt_x[W-1], tgt_x} - {cx_r[W-1], cx_r};
  assign ey = {tgt_y[W-1], tgt_y} - {cy_r[W-1], cy_r};
  assign ez = {tgt_z[W-1], tgt_z} - {cz_r[W-1], cz_r};
  assign ax = ex[W] ? -ex : ex;
  assign ay = ey[W] ? -ey : ey;
  assign az = ez[W] ? -ez : ez;

  assign push_data = {ez[W], ey[W], ex[W], az[W-1:0], ay[W-1:0], ax[W-1:0]};

endmodule
`default_nettype wire

FILE: src/svrc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svrc_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module svrc_fifo import svrc_pkg::*; #(
  parameter int DW = 75
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire logic [DW-1:0] push_data,
  output logic               pop_valid,
  input  wire logic          pop_en,
  output logic [DW-1:0]      pop_data,
  output svrc_qstat_t        stat
);

  logic [DW-1:0]     mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign stat.full   = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign stat.empty  = (cnt_r == '0);
  assign push_ready  = !stat.full;
  assign pop_valid   = !stat.empty;
  assign pop_data    = mem[rd_r];
  assign do_push     = push_valid && push_ready;
  assign do_pop      = pop_en && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: src/svrc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svrc_back
// Squares, bit-per-stage square root, gain scaling and three
// bit-per-stage dividers; ends in the result register.
// ----------------------------------------------------------------------------
module svrc_back import svrc_pkg::*; #(
  parameter int W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output logic                  pop_en,
  input  wire logic [3*W+2:0]   pop_data,
  input  wire logic [W-2:0]     max_torque,
  input  wire logic [GAIN_W-1:0] gain,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [W-1:0]          tq_x,
  output logic [W-1:0]          tq_y,
  output logic [W-1:0]          tq_z
);

  localparam int PW  = 3*W+3;        // payload: mags and signs
  localparam int SW  = W+1;          // root bits
  localparam int SQ  = 2*W+2;        // sum of squares
  localparam int SPW = SW+GAIN_W;    // length * gain
  localparam int MPW = W-1+GAIN_FRAC;
  localparam int QW  = W-1;          // quotient bits
  localparam int NW  = 2*W-1;        // numerator

  logic en;
  assign en     = !out_valid || out_ready;
  assign pop_en = en;

  // ---- pop, squares, sum
  logic          v0_r, v1_r, v2_r;
  logic [PW-1:0] p0_r, p1_r, p2_r;
  logic [2*W-1:0] sq_r [3];
  logic [SQ-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= pop_valid; v1_r <= v0_r; v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= pop_data;
      p1_r <= p0_r;
      p2_r <= p1_r;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (2*W)'(p0_r[i*W +: W]) * (2*W)'(p0_r[i*W +: W]);
      end
      sum_r <= SQ'(sq_r[0]) + SQ'(sq_r[1]) + SQ'(sq_r[2]);
    end
  end

  // ---- square root, one result bit per stage
  logic          vq_r [SW];
  logic [PW-1:0] pq_r [SW];
  logic [SQ-1:0] op_r [SW];
  logic [SQ-1:0] rs_r [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam logic [SQ-1:0] ONE = SQ'(1) << (2*(SW-1-k));
    logic          vi;
    logic [PW-1:0] pi;
    logic [SQ-1:0] opi, rsi, trial;
    if (k == 0) begin : g_first
      assign vi = v2_r; assign pi = p2_r; assign opi = sum_r; assign rsi = '0;
    end else begin : g_next
      assign vi = vq_r[k-1]; assign pi = pq_r[k-1];
      assign opi = op_r[k-1]; assign rsi = rs_r[k-1];
    end
    assign trial = rsi + ONE;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[k] <= 1'b0;
      end else if (en) begin
        vq_r[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pq_r[k] <= pi;
        if (opi >= trial) begin
          op_r[k] <= opi - trial;
          rs_r[k] <= (rsi >> 1) + ONE;
        end else begin
          op_r[k] <= opi;
          rs_r[k] <= rsi >> 1;
        end
      end
    end
  end

  logic [SW-1:0] len;
  assign len = rs_r[SW-1][SW-1:0];

  // ---- magnitude: s = len * gain, m = min(max, max * s)
  logic           vs_r, vm_r, vn_r;
  logic [PW-1:0]  ps_r, pm_r;
  logic [SW-1:0]  ls_r, lm_r, ln_r;
  logic [SPW-1:0] s_r;
  logic [W-2:0]   m_r;
  logic [MPW-1:0] mprod;
  logic [2:0]     sn_r;
  logic [NW-1:0]  num_r [3];

  assign mprod = MPW'(max_torque) * MPW'(s_r[GAIN_FRAC-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0; vm_r <= 1'b0; vn_r <= 1'b0;
    end else if (en) begin
      vs_r <= vq_r[SW-1]; vm_r <= vs_r; vn_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= SPW'(len) * SPW'(gain);
      ls_r <= len;
      ps_r <= pq_r[SW-1];
      m_r  <= (|s_r[SPW-1:GAIN_FRAC]) ? max_torque : mprod[MPW-1:GAIN_FRAC];
      lm_r <= ls_r;
      pm_r <= ps_r;
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= NW'(m_r) * NW'(pm_r[i*W +: W]);
      end
      ln_r <= lm_r;
      sn_r <= pm_r[3*W +: 3];
    end
  end

  // ---- divide m*|e| by len, one quotient bit per stage, three lanes
  logic          vd_r [QW];
  logic [SW-1:0] ld_r [QW];
  logic [2:0]    sd_r [QW];
  logic [NW-1:0] rm_r [QW][3];
  logic [QW-1:0] qd_r [QW][3];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW-1-k;
    logic          vi;
    logic [SW-1:0] li;
    logic [2:0]    si;
    logic [NW-1:0] ri [3];
    logic [QW-1:0] qi [3];
    logic [NW-1:0] dv;
    if (k == 0) begin : g_first
      assign vi = vn_r; assign li = ln_r; assign si = sn_r;
      for (genvar j = 0; j < 3; j++) begin : g_l
        assign ri[j] = num_r[j]; assign qi[j] = '0;
      end
    end else begin : g_next
      assign vi = vd_r[k-1]; assign li = ld_r[k-1]; assign si = sd_r[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_l
        assign ri[j] = rm_r[k-1][j]; assign qi[j] = qd_r[k-1][j];
      end
    end
    assign dv = NW'(li) << B;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en) begin
        vd_r[k] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ld_r[k] <= li;
        sd_r[k] <= si;
        for (int j = 0; j < 3; j++) begin
          if (ri[j] >= dv) begin
            rm_r[k][j] <= ri[j] - dv;
            qd_r[k][j] <= qi[j] | (QW'(1) << B);
          end else begin
            rm_r[k][j] <= ri[j];
            qd_r[k][j] <= qi[j];
          end
        end
      end
    end
  end

  // ---- result register; zero length gives zero torque
  logic         ov_r;
  logic [W-1:0] tq_r [3];
  logic         zl;
  logic [W-1:0] mg [3];

  assign zl = (ld_r[QW-1] == '0);
  for (genvar j = 0; j < 3; j++) begin : g_out
    assign mg[j] = zl ? '0 : {1'b0, qd_r[QW-1][j]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vd_r[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        tq_r[j] <= sd_r[QW-1][j] ? -mg[j] : mg[j];
      end
    end
  end

  assign out_valid = ov_r;
  assign tq_x = tq_r[0];
  assign tq_y = tq_r[1];
  assign tq_z = tq_r[2];

endmodule
`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Rate controller testbench
// Drives measured velocity requests and checks every torque result against an
// in-bench predictor of the proportional controller with magnitude limit.
// ----------------------------------------------------------------------------
module tb import svrc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = 24;
  localparam int DW = ((3*VW+7)/8)*8;
  localparam int DRAIN = 2*VW + 8 + 40;

  typedef logic signed [VW-1:0] val_t;
  typedef struct packed {
    val_t z;
    val_t y;
    val_t x;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request channel
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;   // current_x, current_y, current_z (lowest first)
  // result channel
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;       // torque_x, torque_y, torque_z (lowest first)
  // register port
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  always #5 clk = ~clk;

  saturated_vector_rate_controller_unit #(.VALUE_WIDTH(VW)) i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  // Predictor's copy of the registers
  val_t        tgt_x, tgt_y, tgt_z;
  logic [VW-2:0] torque_lim;
  logic [23:0] gain;

  vec_t torque_q[$];
  int   errors = 0;
  int   send_idle = 0;   // percent of cycles the sender idles
  int   recv_stall = 0;  // percent of cycles the receiver stalls

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (64'd1 << b);
      // full-width square so high trial bits cannot wrap
      if (128'(c) * 128'(c) <= 128'(v)) r = c;
    end
    return r;
  endfunction

  function automatic vec_t torque_of(input vec_t cur);
    vec_t         res;
    logic signed [VW:0] e [3];
    logic [VW:0]  mag [3];
    logic [63:0]  sumsq, len, s, m;
    logic [127:0] q;
    e[0] = tgt_x - cur.x;
    e[1] = tgt_y - cur.y;
    e[2] = tgt_z - cur.z;
    sumsq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = e[i] < 0 ? -e[i] : e[i];
      sumsq += 64'(mag[i]) * 64'(mag[i]);
    end
    len = isqrt(sumsq);
    res = '0;
    if (len == 0) return res;
    s = len * 64'(gain);
    // length*gain at or above one pins the magnitude at the limit
    m = (s >= (64'd1 << 24)) ? 64'(torque_lim) : (64'(torque_lim) * s) >> 24;
    for (int i = 0; i < 3; i++) begin
      q = (128'(m) * 128'(mag[i])) / 128'(len);
      if (q > 128'((1 << (VW-1)) - 1)) q = 128'((1 << (VW-1)) - 1);
      case (i)
        0: res.x = e[i] < 0 ? -val_t'(q) : val_t'(q);
        1: res.y = e[i] < 0 ? -val_t'(q) : val_t'(q);
        default: res.z = e[i] < 0 ? -val_t'(q) : val_t'(q);
      endcase
    end
    return res;
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(idx) << 2; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_TARGET_X:   tgt_x = v[VW-1:0];
      REG_TARGET_Y:   tgt_y = v[VW-1:0];
      REG_TARGET_Z:   tgt_z = v[VW-1:0];
      REG_MAX_TORQUE: torque_lim = v[VW-2:0];
      REG_FALLOFF:    gain = v[23:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] tx, ty, tz, mt, g);
    write_reg(REG_TARGET_X, tx);
    write_reg(REG_TARGET_Y, ty);
    write_reg(REG_TARGET_Z, tz);
    write_reg(REG_MAX_TORQUE, mt);
    write_reg(REG_FALLOFF, g);
  endtask

  // Send one request, predicting at acceptance; valid drops only while idling
  task automatic send(input vec_t v);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= DW'(v);
    do @(posedge clk); while (!in_tready);
    torque_q.push_back(torque_of(v));
  endtask

  // Wait for the pipeline to empty before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (torque_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic val_t rnd_val(input int mode);
    case (mode)
      0: return val_t'($urandom);
      1: return val_t'($urandom_range(512) - 256);
      2: return val_t'($urandom_range(1 << 14) - (1 << 13));
      default: return $urandom_range(1) ? val_t'(24'h7fffff) : val_t'(24'h800000);
    endcase
  endfunction

  // Receiver: random stall and compare against the oldest prediction
  always @(posedge clk) begin
    vec_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[3*VW-1:0];
      if (torque_q.size() == 0) begin
        report("unexpected result", got.x, 0);
      end else begin
        want = torque_q.pop_front();
        if (got.x !== want.x) report("torque_x", got.x, want.x);
        if (got.y !== want.y) report("torque_y", got.y, want.y);
        if (got.z !== want.z) report("torque_z", got.z, want.z);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic test_directed();
    vec_t v;
    set_all(0, 0, 0, 32'h7fffff, 32'h10000);
    send('0);                                // zero error
    v.x = 24'h7fffff; v.y = 24'h800000; v.z = 24'h7fffff; send(v);
    v.x = 24'h800000; v.y = 24'h800000; v.z = 24'h800000; send(v);
    v.x = 24'h000001; v.y = 0; v.z = 0; send(v);
    v.x = 0; v.y = 24'hffffff; v.z = 0; send(v);
    v.x = 0; v.y = 0; v.z = 24'h000300; send(v);
    drain();
    // extreme targets, tiny gain, extra bits above fields
    set_all(32'hff7fffff, 32'h00800000, 32'h12345678, 32'hffffffff, 32'h00000001);
    send('0);
    v.x = 24'h7fffff; v.y = 24'h7fffff; v.z = 24'h800000; send(v);
    v.x = 24'h800000; v.y = 24'h800000; v.z = 24'h7fffff; send(v);
    v.x = 24'h7fffff; v.y = 24'h800000; v.z = 24'h345678; send(v);
    drain();
    // largest gain, zero limit, then zero gain
    set_all(24'h000100, 24'hffff00, 0, 0, 32'hffffff);
    v.x = 0; v.y = 0; v.z = 24'h000080; send(v);
    v.x = 24'h000100; v.y = 24'hffff00; v.z = 0; send(v);
    drain();
    set_all(24'h000100, 24'hffff00, 0, 32'h400000, 0);
    v.x = 0; v.y = 0; v.z = 24'h000080; send(v);
    v.x = 24'h7fffff; v.y = 24'h12; v.z = 24'h800000; send(v);
    drain();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    vec_t v;
    int   mode;
    send_idle = idle;
    recv_stall = stall;
    // fresh setting per phase, mostly with small gains
    set_all($urandom, $urandom, $urandom,
            $urandom_range(1) ? $urandom : $urandom_range(1 << 16),
            $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 12));
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(3);
      if ($urandom_range(7) == 0) begin
        v.x = tgt_x; v.y = tgt_y; v.z = tgt_z;  // zero error case
        if ($urandom_range(1)) v.x = tgt_x + val_t'($urandom_range(2) - 1);
      end else begin
        v.x = (mode == 1 || mode == 2) ? tgt_x + rnd_val(mode) : rnd_val(mode);
        v.y = (mode == 1 || mode == 2) ? tgt_y + rnd_val(mode) : rnd_val(mode);
        v.z = (mode == 1 || mode == 2) ? tgt_z + rnd_val(mode) : rnd_val(mode);
      end
      send(v);
      if (n % 50 == 49) begin
        drain();
        set_all($urandom, $urandom, $urandom, $urandom,
                $urandom_range(1) ? $urandom : $urandom_range(1 << 10));
      end
    end
    drain();
  endtask

  initial begin
    tgt_x = '0; tgt_y = '0; tgt_z = '0; torque_lim = '0; gain = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send('0);            // reset registers: everything zero
    drain();
    test_directed();
    test_random(300, 0, 0);
    test_random(280, 45, 0);
    test_random(280, 0, 45);
    test_random(280, 36, 36);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: files.f
src/svrc_pkg.sv
src/svrc_front.sv
src/svrc_fifo.sv
src/svrc_back.sv
src/saturated_vector_rate_controller_unit.sv
test/tb.sv
